// File: design/sck_pkg.sv
package sck_pkg;

	localparam int COORD_FRAC_BITS_DEF = 24;

	localparam logic [30:0] Q_ONE    = 31'd1073741824;
	localparam logic [30:0] Q_HALF   = 31'd536870912;
	localparam logic [31:0] K8PI_Q30 = 32'd2734261102;

	// distance stage result
	typedef struct packed {
		logic [32:0] r;
		logic [30:0] h;
		logic        axes_in;
	} dist_t;

	// ratio stage result
	typedef struct packed {
		logic [30:0] q;
		logic [30:0] hh;
		logic        ok;
		logic        dense;
	} ratio_t;

	// polynomial stage result
	typedef struct packed {
		logic [62:0] a;
		logic [92:0] h3;
		logic        ok;
		logic        dense;
	} poly_t;

endpackage

// File: design/sck_sqrt.sv
module sck_sqrt import sck_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] particle_x,
	input  logic signed [31:0] particle_y,
	input  logic signed [31:0] particle_z,
	input  logic signed [31:0] sample_x,
	input  logic signed [31:0] sample_y,
	input  logic signed [31:0] sample_z,
	input  logic        [30:0] smoothing_length,
	input  logic        [30:0] grid_half_width,
	output logic               out_valid,
	output dist_t              out_dist
);

	logic [32:0] dx, dy, dz, ax, ay, az;
	logic [32:0] ax_s1, ay_s1, az_s1;
	logic [30:0] h_s1, h_s2;
	logic        axes_s1, axes_s2;
	logic        v_s1, v_s2;
	logic [65:0] sqx_s2, sqy_s2, sqz_s2;

	// sqrt pipeline, index 0 is the sum stage
	logic [65:0] sum_s  [0:33];
	logic [35:0] rem_s  [0:33];
	logic [32:0] root_s [0:33];
	logic [30:0] h_s    [0:33];
	logic        axes_s [0:33];
	logic        v_s    [0:33];

	assign dx = {particle_x[31], particle_x} - {sample_x[31], sample_x};
	assign dy = {particle_y[31], particle_y} - {sample_y[31], sample_y};
	assign dz = {particle_z[31], particle_z} - {sample_z[31], sample_z};
	assign ax = dx[32] ? (33'd0 - dx) : dx;
	assign ay = dy[32] ? (33'd0 - dy) : dy;
	assign az = dz[32] ? (33'd0 - dz) : dz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= ax;
			ay_s1   <= ay;
			az_s1   <= az;
			h_s1    <= smoothing_length;
			axes_s1 <= (ax < {2'b00, grid_half_width}) && (ay < {2'b00, grid_half_width})
				&& (az < {2'b00, grid_half_width});
			sqx_s2  <= ax_s1 * ax_s1;
			sqy_s2  <= ay_s1 * ay_s1;
			sqz_s2  <= az_s1 * az_s1;
			h_s2    <= h_s1;
			axes_s2 <= axes_s1;
			sum_s[0]  <= sqx_s2 + sqy_s2 + sqz_s2;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			h_s[0]    <= h_s2;
			axes_s[0] <= axes_s2;
		end
	end

	// one root bit per stage
	for (genvar k = 0; k < 33; k++) begin : g_step
		localparam int B = 2 * (32 - k);
		logic [35:0] cur, trial;

		assign cur   = {rem_s[k][33:0], sum_s[k][B+1:B]};
		assign trial = {1'b0, root_s[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sum_s[k+1]  <= sum_s[k];
				h_s[k+1]    <= h_s[k];
				axes_s[k+1] <= axes_s[k];
				if (cur >= trial) begin
					rem_s[k+1]  <= cur - trial;
					root_s[k+1] <= {root_s[k][31:0], 1'b1};
				end else begin
					rem_s[k+1]  <= cur;
					root_s[k+1] <= {root_s[k][31:0], 1'b0};
				end
			end
		end
	end

	assign out_valid        = v_s[33];
	assign out_dist.r       = root_s[33];
	assign out_dist.h       = h_s[33];
	assign out_dist.axes_in = axes_s[33];

endmodule

// File: design/sck_qdiv.sv
module sck_qdiv import sck_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  dist_t       in_dist,
	input  logic [30:0] grid_half_width,
	output logic        out_valid,
	output ratio_t      out_ratio
);

	logic        normal, dense, vld;
	logic [30:0] d, hh;
	logic [62:0] num, lim;

	logic [62:0] rem_s   [0:31];
	logic [30:0] d_s     [0:31];
	logic [30:0] q_s     [0:31];
	logic [30:0] hh_s    [0:31];
	logic        ok_s    [0:31];
	logic        dense_s [0:31];
	logic        v_s     [0:31];

	assign normal = (in_dist.h != '0) && (in_dist.r < {2'b00, in_dist.h});
	assign dense  = !normal && in_dist.axes_in;
	assign vld    = normal || dense;
	assign d      = normal ? in_dist.h : grid_half_width;
	assign hh     = (normal || in_dist.h >= grid_half_width) ? in_dist.h : grid_half_width;
	assign num    = {in_dist.r, 30'd0};
	// quotient stays within one when r * 2^30 < (2^30 + 1) * d
	assign lim    = {2'b00, d, 30'd0} + {32'd0, d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]   <= num;
			d_s[0]     <= d;
			q_s[0]     <= '0;
			hh_s[0]    <= hh;
			ok_s[0]    <= vld && (num < lim);
			dense_s[0] <= dense;
		end
	end

	for (genvar k = 0; k < 31; k++) begin : g_step
		localparam int I = 30 - k;
		logic [62:0] sub;

		assign sub = {32'd0, d_s[k]} << I;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k+1]     <= d_s[k];
				hh_s[k+1]    <= hh_s[k];
				ok_s[k+1]    <= ok_s[k];
				dense_s[k+1] <= dense_s[k];
				if (rem_s[k] >= sub) begin
					rem_s[k+1] <= rem_s[k] - sub;
					q_s[k+1]   <= {q_s[k][29:0], 1'b1};
				end else begin
					rem_s[k+1] <= rem_s[k];
					q_s[k+1]   <= {q_s[k][29:0], 1'b0};
				end
			end
		end
	end

	assign out_valid       = v_s[31];
	assign out_ratio.q     = q_s[31];
	assign out_ratio.hh    = hh_s[31];
	assign out_ratio.ok    = ok_s[31];
	assign out_ratio.dense = dense_s[31];

endmodule

// File: design/sck_poly.sv
module sck_poly import sck_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  ratio_t in_ratio,
	output logic   out_valid,
	output poly_t  out_poly
);

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        near_s1, near_s2, near_s3;
	logic        ok_s1, ok_s2, ok_s3, ok_s4, ok_s5;
	logic        dense_s1, dense_s2, dense_s3, dense_s4, dense_s5;
	logic [30:0] x_s1, x_s2;
	logic [30:0] hh_s1;
	logic [61:0] h2_s1;
	logic [61:0] plo_s2, phi_s2;
	logic [30:0] x2_s2, x2_s3;
	logic [30:0] x3_s3;
	logic [92:0] h3_s3, h3_s4, h3_s5;
	logic [31:0] p_s4;
	logic [62:0] a_s5;
	logic [61:0] xx, x2x;
	logic signed [35:0] pn;

	assign xx  = x_s1 * x_s1;
	assign x2x = x2_s2 * x_s2;
	assign pn  = $signed({5'd0, Q_ONE}) - $signed({5'd0, x2_s3} * 36'd6)
		+ $signed({5'd0, x3_s3} * 36'd6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_s1  <= in_ratio.q <= Q_HALF;
			x_s1     <= (in_ratio.q <= Q_HALF) ? in_ratio.q : (Q_ONE - in_ratio.q);
			hh_s1    <= in_ratio.hh;
			h2_s1    <= in_ratio.hh * in_ratio.hh;
			ok_s1    <= in_ratio.ok;
			dense_s1 <= in_ratio.dense;

			x2_s2    <= xx[60:30];
			x_s2     <= x_s1;
			plo_s2   <= h2_s1[30:0] * hh_s1;
			phi_s2   <= h2_s1[61:31] * hh_s1;
			near_s2  <= near_s1;
			ok_s2    <= ok_s1;
			dense_s2 <= dense_s1;

			x2_s3    <= x2_s2;
			x3_s3    <= x2x[60:30];
			h3_s3    <= {31'd0, plo_s2} + {phi_s2, 31'd0};
			near_s3  <= near_s2;
			ok_s3    <= ok_s2;
			dense_s3 <= dense_s2;

			// near branch clamps at zero, far branch doubles u^3
			if (near_s3) begin
				p_s4 <= pn[35] ? 32'd0 : pn[31:0];
			end else begin
				p_s4 <= {x3_s3, 1'b0};
			end
			h3_s4    <= h3_s3;
			ok_s4    <= ok_s3;
			dense_s4 <= dense_s3;

			a_s5     <= {31'd0, K8PI_Q30} * {31'd0, p_s4};
			h3_s5    <= h3_s4;
			ok_s5    <= ok_s4;
			dense_s5 <= dense_s4;
		end
	end

	assign out_valid      = v_s5;
	assign out_poly.a     = a_s5;
	assign out_poly.h3    = h3_s5;
	assign out_poly.ok    = ok_s5;
	assign out_poly.dense = dense_s5;

endmodule

// File: design/sck_wdiv.sv
module sck_wdiv import sck_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  poly_t       in_poly,
	output logic        out_valid,
	output logic [47:0] kernel_value,
	output logic        dense_used,
	output logic        saturated
);

	localparam int S   = 3 * COORD_FRAC_BITS - 44;
	localparam int A_W = 63 + ((S > 0) ? S : 0);
	localparam int RW  = (A_W > 141) ? A_W : 141;

	logic [RW-1:0] num, lim;

	logic [RW-1:0] rem_s   [0:48];
	logic [92:0]   h3_s    [0:48];
	logic [47:0]   q_s     [0:48];
	logic          sat_s   [0:48];
	logic          ok_s    [0:48];
	logic          dense_s [0:48];
	logic          v_s     [0:48];

	logic [47:0]   w_q;
	logic          dense_q, sat_q, v_q;

	if (S >= 0) begin : g_left
		assign num = RW'(in_poly.a) << S;
	end else begin : g_right
		assign num = RW'(in_poly.a >> (-S));
	end

	assign lim = RW'(in_poly.h3) << 48;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
			v_q    <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			v_q    <= v_s[48];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]   <= num;
			h3_s[0]    <= in_poly.h3;
			q_s[0]     <= '0;
			sat_s[0]   <= num >= lim;
			ok_s[0]    <= in_poly.ok;
			dense_s[0] <= in_poly.dense;
		end
	end

	for (genvar k = 0; k < 48; k++) begin : g_step
		localparam int I = 47 - k;
		logic [RW-1:0] sub;

		assign sub = RW'(h3_s[k]) << I;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				h3_s[k+1]    <= h3_s[k];
				sat_s[k+1]   <= sat_s[k];
				ok_s[k+1]    <= ok_s[k];
				dense_s[k+1] <= dense_s[k];
				if (rem_s[k] >= sub) begin
					rem_s[k+1] <= rem_s[k] - sub;
					q_s[k+1]   <= {q_s[k][46:0], 1'b1};
				end else begin
					rem_s[k+1] <= rem_s[k];
					q_s[k+1]   <= {q_s[k][46:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dense_q <= dense_s[48];
			sat_q   <= ok_s[48] && sat_s[48];
			if (!ok_s[48]) begin
				w_q <= '0;
			end else if (sat_s[48]) begin
				w_q <= '1;
			end else begin
				w_q <= q_s[48];
			end
		end
	end

	assign out_valid    = v_q;
	assign kernel_value = w_q;
	assign dense_used   = dense_q;
	assign saturated    = sat_q;

endmodule

// File: design/sph_cubic_spline_kernel.sv
// 3d cubic spline sph kernel: each input item carries a particle position, a sample
// position (signed fixed point with COORD_FRAC_BITS fraction bits) and the smoothing
// length h; each output item carries the kernel weight W as unsigned q32.16 with a
// saturation flag and a dense flag that marks when the grid half-width replaced h.
// one item is taken every clock unless the output stalls; the pipeline is made up
// mainly of the bit-per-stage square root (33 stages), the ratio divider (31 stages)
// and the weight divider by h^3 (48 stages). a stall on the output freezes the whole
// pipeline, so nothing is lost or repeated. grid_half_width is written over the cfg
// channel, which is always ready; write it only while no items are in flight.
module sph_cubic_spline_kernel import sck_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// particle_x, particle_y, particle_z, sample_x, sample_y, sample_z,
	// smoothing_length, zero pad bit
	input  logic [223:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// kernel_value
	output logic [47:0]  m_axis_tdata,
	// dense_used, saturated
	output logic [1:0]   m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	// grid_half_width
	input  logic [30:0]  cfg_data
);

	logic        en;
	logic [30:0] grid_half_q;
	logic        dist_v, ratio_v, poly_v;
	dist_t       dist_res;
	ratio_t      ratio;
	poly_t       poly;

	// global advance: move when the output slot is empty or being taken
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	// grid half-width register, zero disables the dense fallback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_half_q <= '0;
		end else if (cfg_valid) begin
			grid_half_q <= cfg_data;
		end
	end

	// axis offsets, squared distance and integer root r
	sck_sqrt u_sqrt (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.in_valid         (s_axis_tvalid),
		.particle_x       (s_axis_tdata[31:0]),
		.particle_y       (s_axis_tdata[63:32]),
		.particle_z       (s_axis_tdata[95:64]),
		.sample_x         (s_axis_tdata[127:96]),
		.sample_y         (s_axis_tdata[159:128]),
		.sample_z         (s_axis_tdata[191:160]),
		.smoothing_length (s_axis_tdata[222:192]),
		.grid_half_width  (grid_half_q),
		.out_valid        (dist_v),
		.out_dist         (dist_res)
	);

	// pick h or grid half-width, then q = r * 2^30 / d
	sck_qdiv u_qdiv (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (dist_v),
		.in_dist         (dist_res),
		.grid_half_width (grid_half_q),
		.out_valid       (ratio_v),
		.out_ratio       (ratio)
	);

	// spline polynomial times 8/pi, and h^3
	sck_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ratio_v),
		.in_ratio  (ratio),
		.out_valid (poly_v),
		.out_poly  (poly)
	);

	// scale, divide by h^3 and clamp to 48 bits
	sck_wdiv #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_wdiv (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (poly_v),
		.in_poly      (poly),
		.out_valid    (m_axis_tvalid),
		.kernel_value (m_axis_tdata),
		.dense_used   (m_axis_tuser[0]),
		.saturated    (m_axis_tuser[1])
	);

endmodule

// File: sim/tb.sv
module tb;
	import sck_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC         = COORD_FRAC_BITS_DEF;
	localparam int LATENCY      = 130;   // pipeline depth plus some margin
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [30:0] G_MAX = 31'h7FFF_FFFF;

	// one kernel evaluation request
	typedef struct {
		logic signed [31:0] px, py, pz, sx, sy, sz;
		logic [30:0]        h;
	} pair_t;

	// one kernel weight result
	typedef struct {
		logic [47:0] weight;
		logic        dense;
		logic        sat;
	} weight_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [223:0] s_axis_tdata;   // px, py, pz, sx, sy, sz, h, zero pad
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [47:0]  m_axis_tdata;   // kernel_value
	logic [1:0]   m_axis_tuser;   // dense_used, saturated
	logic         cfg_valid;
	logic         cfg_ready;
	logic [30:0]  cfg_data;

	sph_cubic_spline_kernel uut (.*);

	// testbench state
	pair_t   pair_queue[$];     // pairs waiting to be driven
	weight_t weight_queue[$];   // weights the block still owes us
	pair_t   pair_on_bus;
	logic [30:0] grid_half;     // our copy of the grid half-width register
	int      send_gap, recv_stall;
	bit      no_idle;           // phases with back-to-back traffic
	int      errors;
	int      cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// integer square root of a 66-bit sum of squares
	function automatic logic [33:0] isqrt66(input logic [65:0] s);
		logic [67:0] rem;
		logic [67:0] trial;
		logic [33:0] root;
		rem  = '0;
		root = '0;
		for (int i = 32; i >= 0; i--) begin
			rem   = (rem << 2) | s[2*i +: 2];
			trial = {root, 2'b01};
			if (rem >= trial) begin
				rem  = rem - trial;
				root = {root[32:0], 1'b1};
			end else begin
				root = {root[32:0], 1'b0};
			end
		end
		return root;
	endfunction

	// spline polynomial in q30, near and far branches
	function automatic longint spline_q30(input longint q);
		longint q2, q3, p, u, u2, u3;
		if (q <= longint'(Q_HALF)) begin
			q2 = (q * q) >>> 30;
			q3 = (q2 * q) >>> 30;
			p  = longint'(Q_ONE) - 6 * q2 + 6 * q3;
			return (p < 0) ? 0 : p;
		end
		u  = longint'(Q_ONE) - q;
		u2 = (u * u) >>> 30;
		u3 = (u2 * u) >>> 30;
		return 2 * u3;
	endfunction

	// kernel weight for one pair under grid half-width g
	function automatic weight_t kernel_weight(input pair_t it, input logic [30:0] g);
		logic signed [32:0] dx, dy, dz;
		logic [65:0]  ax, ay, az, sum;
		logic [33:0]  r;
		logic [127:0] q, hh, a;
		weight_t      res;
		bit           ok;
		dx = 33'(it.px) - 33'(it.sx);
		dy = 33'(it.py) - 33'(it.sy);
		dz = 33'(it.pz) - 33'(it.sz);
		ax = 66'(dx < 0 ? -dx : dx);
		ay = 66'(dy < 0 ? -dy : dy);
		az = 66'(dz < 0 ? -dz : dz);
		sum = ax * ax + ay * ay + az * az;
		r   = isqrt66(sum);
		res = '{weight: '0, dense: 1'b0, sat: 1'b0};
		ok  = 0;
		hh  = 128'(it.h);
		q   = '0;
		if (it.h != 0 && 34'(it.h) > r) begin
			q  = (128'(r) << 30) / 128'(it.h);
			ok = 1;
		end else if (ax < 66'(g) && ay < 66'(g) && az < 66'(g)) begin
			res.dense = 1'b1;
			q  = (128'(r) << 30) / 128'(g);
			hh = 128'((it.h < g) ? g : it.h);
			ok = 1;
		end
		if (ok && q <= 128'(Q_ONE)) begin
			a = 128'(K8PI_Q30) * 128'(spline_q30(longint'(q)));
			if (3 * FRAC - 44 > 0)
				a = a << (3 * FRAC - 44);
			else
				a = a >> (44 - 3 * FRAC);
			a = ((a / hh) / hh) / hh;
			if (a > 128'h0000_FFFF_FFFF_FFFF) begin
				res.sat    = 1'b1;
				res.weight = '1;
			end else begin
				res.weight = a[47:0];
			end
		end
		return res;
	endfunction

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 19);
	endfunction

	// driver: a new pair goes on the bus once the old one is taken and its gap is over
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				weight_queue.push_back(kernel_weight(pair_on_bus, grid_half));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap      <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pair_queue.size() > 0) begin
					pair_on_bus = pair_queue.pop_front();
					s_axis_tdata <= {1'b0, pair_on_bus.h, pair_on_bus.sz, pair_on_bus.sy,
						pair_on_bus.sx, pair_on_bus.pz, pair_on_bus.py, pair_on_bus.px};
					s_axis_tvalid <= 1'b1;
					send_gap      <= draw_wait();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare every taken weight with the oldest one predicted
	always @(posedge clk or negedge arst_n) begin
		int      stall;
		weight_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall    <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if (weight_queue.size() == 0) begin
				$display("%0t: unexpected item weight=%h user=%b", $time,
					m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = weight_queue.pop_front();
				if (m_axis_tdata !== want.weight) begin
					$display("%0t: kernel_value expected %h actual %h", $time,
						want.weight, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser[0] !== want.dense) begin
					$display("%0t: dense_used expected %b actual %b", $time,
						want.dense, m_axis_tuser[0]);
					errors++;
				end
				if (m_axis_tuser[1] !== want.sat) begin
					$display("%0t: saturated expected %b actual %b", $time,
						want.sat, m_axis_tuser[1]);
					errors++;
				end
			end
			stall = draw_wait();
			recv_stall    <= stall;
			m_axis_tready <= (stall == 0);
		end else if (recv_stall > 0) begin
			recv_stall    <= recv_stall - 1;
			m_axis_tready <= (recv_stall == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic pair_t make_pair(input logic signed [31:0] px, py, pz,
			input logic signed [31:0] dx, dy, dz, input logic [30:0] h);
		pair_t p;
		p.px = px; p.py = py; p.pz = pz;
		p.sx = px - dx; p.sy = py - dy; p.sz = pz - dz;
		p.h  = h;
		return p;
	endfunction

	// random offset in [-bound, bound], bound up to 2^31 - 1
	function automatic logic signed [31:0] rand_offset(input longint bound);
		longint v;
		v = longint'({$urandom, $urandom}) % (bound + 1);
		if (v < 0)
			v = -v;
		return $urandom_range(0, 1) ? 32'(-v) : 32'(v);
	endfunction

	// random scale, most of it near realistic sizes
	function automatic logic [30:0] rand_length();
		logic [30:0] v;
		v = 31'($urandom) >> $urandom_range(0, 30);
		return (v == 0) ? 31'd1 : v;
	endfunction

	task automatic write_grid_half(input logic [30:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		grid_half = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pair_queue.size() > 0 || s_axis_tvalid || weight_queue.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// one phase of random pairs
	task automatic random_pairs(input int n);
		logic [30:0] h, scale;
		pair_t p;
		for (int i = 0; i < n; i++) begin
			h = rand_length();
			case ($urandom_range(0, 9))
				0: begin
					// raw noise over every bit
					p.px = $urandom; p.py = $urandom; p.pz = $urandom;
					p.sx = $urandom; p.sy = $urandom; p.sz = $urandom;
					p.h  = 31'($urandom);
					if (p.h == 0)
						p.h = 1;
				end
				1, 2: begin
					// offsets on the scale of the grid half-width, dense cases
					scale = (grid_half == 0) ? h : grid_half;
					p = make_pair($urandom, $urandom, $urandom,
						rand_offset(scale), rand_offset(scale), rand_offset(scale),
						(h > scale) ? 31'(scale >> 1) + 31'd1 : h);
				end
				default: begin
					// offsets around h, landing in both spline branches
					p = make_pair($urandom, $urandom, $urandom,
						rand_offset(h), rand_offset(h), rand_offset(h), h);
				end
			endcase
			pair_queue.push_back(p);
		end
	endtask

	initial begin
		logic [30:0] one_unit;
		one_unit      = 31'(1) << FRAC;
		errors        = 0;
		cycles        = 0;
		no_idle       = 0;
		grid_half     = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		arst_n        = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		write_grid_half('0);
		// directed: center of the kernel, branch edges, extremes
		pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0, one_unit));
		pair_queue.push_back(make_pair(0, 0, 0, 32'(one_unit >> 1), 0, 0, one_unit));
		pair_queue.push_back(make_pair(0, 0, 0, 32'(one_unit >> 1) + 1, 0, 0, one_unit));
		pair_queue.push_back(make_pair(0, 0, 0, 32'(one_unit) - 1, 0, 0, one_unit));
		pair_queue.push_back(make_pair(0, 0, 0, 32'(one_unit), 0, 0, one_unit));
		pair_queue.push_back(make_pair(5, 5, 5, 0, 0, 0, 31'd1));      // saturates
		pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0, G_MAX));
		pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0, 31'd1 << 20)); // small h, still far below saturation
		pair_queue.push_back('{px: 32'sh7FFF_FFFF, py: 32'sh7FFF_FFFF, pz: 32'sh7FFF_FFFF,
			sx: 32'sh8000_0000, sy: 32'sh8000_0000, sz: 32'sh8000_0000, h: G_MAX});
		pair_queue.push_back('{px: 32'sh8000_0000, py: 32'sh7FFF_FFFF, pz: 0,
			sx: 32'sh7FFF_FFFF, sy: 32'sh8000_0000, sz: -1, h: 31'd1});
		pair_queue.push_back(make_pair(0, 0, 0, 32'sh4000_0000, 32'sh4000_0000,
			32'sh4000_0000, G_MAX));
		drain();

		// dense fallback at one unit: offsets just inside and just outside
		write_grid_half(one_unit);
		pair_queue.push_back(make_pair(0, 0, 0, 32'(one_unit) - 1, 0, 0, one_unit >> 2));
		pair_queue.push_back(make_pair(0, 0, 0, 32'(one_unit), 0, 0, one_unit >> 2));
		pair_queue.push_back(make_pair(0, 0, 0, 32'(one_unit >> 1), 32'(one_unit >> 1),
			32'(one_unit >> 1), 31'd1));
		pair_queue.push_back(make_pair(0, 0, 0, 32'(one_unit >> 2), 0, 0, one_unit << 1));
		pair_queue.push_back(make_pair(0, 0, 0, 32'(one_unit) - 1, 32'(one_unit) - 1,
			32'(one_unit) - 1, one_unit >> 4));
		drain();

		// tiny grid half-width, then the largest
		write_grid_half(31'd1);
		pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0, 31'd1));
		pair_queue.push_back(make_pair(0, 0, 0, 1, 0, 0, 31'd1));
		drain();
		write_grid_half(G_MAX);
		pair_queue.push_back(make_pair(0, 0, 0, 32'sh7FFF_FFFE, 0, 0, 31'd1));
		pair_queue.push_back(make_pair(0, 0, 0, 32'sh7FFF_FFFE, 32'sh7FFF_FFFE,
			32'sh7FFF_FFFE, G_MAX >> 1));
		random_pairs(130);
		drain();

		// random phases over several register settings
		write_grid_half('0);
		random_pairs(130);
		drain();
		no_idle = 1;
		write_grid_half(one_unit);
		random_pairs(130);
		drain();
		no_idle = 0;
		write_grid_half(31'($urandom));
		random_pairs(130);
		drain();
		write_grid_half(rand_length());
		random_pairs(150);
		drain();

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
design/sck_pkg.sv
design/sck_sqrt.sv
design/sck_qdiv.sv
design/sck_poly.sv
design/sck_wdiv.sv
design/sph_cubic_spline_kernel.sv
sim/tb.sv
